### rtl/core/i2c_trm_pkg.sv
// shared types, constants and sequencer state codes for the i2c register transaction master
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package i2c_trm_pkg;

    localparam int PHASE_W = 16;
    localparam int COUNT_W = 5;

    // command codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // r/w bit appended to the device address
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    // pin phase index within one bit or bus condition
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_MIDDLE = 2'd1;
    localparam logic [1:0] PH_LAST   = 2'd2;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'b0000_0000_0000_0001,
        ST_START1  = 16'b0000_0000_0000_0010,
        ST_ADDRW   = 16'b0000_0000_0000_0100,
        ST_ACK1    = 16'b0000_0000_0000_1000,
        ST_SUB     = 16'b0000_0000_0001_0000,
        ST_ACK2    = 16'b0000_0000_0010_0000,
        ST_DATA    = 16'b0000_0000_0100_0000,
        ST_ACK3    = 16'b0000_0000_1000_0000,
        ST_STOPW   = 16'b0000_0001_0000_0000,
        ST_STOPMID = 16'b0000_0010_0000_0000,
        ST_START2  = 16'b0000_0100_0000_0000,
        ST_ADDRR   = 16'b0000_1000_0000_0000,
        ST_ACK4    = 16'b0001_0000_0000_0000,
        ST_RECV    = 16'b0010_0000_0000_0000,
        ST_MACK    = 16'b0100_0000_0000_0000,
        ST_STOPR   = 16'b1000_0000_0000_0000
    } seq_state_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [6:0]         device_addr;
        logic [7:0]         sub_addr;
        logic [7:0]         write_data;
        logic [COUNT_W-1:0] read_count;
        logic               sda_in;
    } trm_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
        logic       cmd_rejected;
    } trm_out_t;

    // step control from the top level to the engine
    typedef struct packed {
        logic               step;
        logic [PHASE_W-1:0] phase_ticks;
    } trm_ctrl_t;

    function automatic logic is_send_step(seq_state_t s);
        return (s == ST_ADDRW) || (s == ST_SUB) || (s == ST_DATA) || (s == ST_ADDRR);
    endfunction

    function automatic logic is_recv_step(seq_state_t s);
        return (s == ST_ACK1) || (s == ST_ACK2) || (s == ST_ACK3) || (s == ST_ACK4)
            || (s == ST_RECV);
    endfunction

    function automatic logic is_start_step(seq_state_t s);
        return (s == ST_START1) || (s == ST_START2);
    endfunction

    function automatic logic is_stop_step(seq_state_t s);
        return (s == ST_STOPW) || (s == ST_STOPMID) || (s == ST_STOPR);
    endfunction

endpackage

### rtl/core/i2c_trm_engine.sv
// per-tick sequencer: transaction state registers and the one-pass next-state logic
// depends on i2c_trm_pkg
`timescale 1ns / 1ps

module i2c_trm_engine #(
    parameter int MAX_READ_BYTES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  i2c_trm_pkg::trm_ctrl_t ctrl,
    input  i2c_trm_pkg::trm_in_t   item,
    output i2c_trm_pkg::trm_out_t  result
);
    import i2c_trm_pkg::*;

    seq_state_t         step_reg,  step_next;
    logic [PHASE_W-1:0] pcnt_reg,  pcnt_next;
    logic [1:0]         pidx_reg,  pidx_next;
    logic [3:0]         bitc_reg,  bitc_next;
    logic [COUNT_W-1:0] bytec_reg, bytec_next;
    logic [7:0]         shift_reg, shift_next;
    logic [6:0]         addr_reg,  addr_next;
    logic [7:0]         sub_reg,   sub_next;
    logic [7:0]         data_reg,  data_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               rd_reg,    rd_next;
    logic               nack_reg,  nack_next;

    always_comb begin
        logic [PHASE_W-1:0] pt;
        logic [PHASE_W:0]   pcnt_inc;
        logic               bit_val;
        logic [COUNT_W:0]   byte_inc;

        step_next  = step_reg;
        pcnt_next  = pcnt_reg;
        pidx_next  = pidx_reg;
        bitc_next  = bitc_reg;
        bytec_next = bytec_reg;
        shift_next = shift_reg;
        addr_next  = addr_reg;
        sub_next   = sub_reg;
        data_next  = data_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        nack_next  = nack_reg;
        result     = '0;
        pcnt_inc   = '0;
        bit_val    = 1'b1;
        byte_inc   = '0;

        pt = (ctrl.phase_ticks == '0) ? PHASE_W'(1) : ctrl.phase_ticks;

        // command handling
        if ((item.mode == MODE_WRITE) || (item.mode == MODE_READ)) begin
            if (step_reg != ST_IDLE) begin
                result.cmd_rejected = 1'b1;
            end else begin
                addr_next = item.device_addr;
                sub_next  = item.sub_addr;
                data_next = item.write_data;
                if (32'(item.read_count) > MAX_READ_BYTES) begin
                    count_next = COUNT_W'(MAX_READ_BYTES);
                end else begin
                    count_next = item.read_count;
                end
                rd_next    = (item.mode == MODE_READ);
                nack_next  = 1'b0;
                pcnt_next  = '0;
                pidx_next  = PH_FIRST;
                bitc_next  = '0;
                bytec_next = '0;
                shift_next = '0;
                step_next  = ST_START1;
            end
        end

        if (step_next == ST_IDLE) begin
            result.scl_out = 1'b1;
            result.sda_out = 1'b1;
        end else begin
            // pin levels of the current phase
            if (is_start_step(step_next)) begin
                result.scl_out = (pidx_next != PH_LAST);
                result.sda_out = (pidx_next == PH_FIRST);
            end else if (is_stop_step(step_next)) begin
                result.scl_out = (pidx_next != PH_FIRST);
                result.sda_out = (pidx_next == PH_LAST);
            end else begin
                bit_val = 1'b1;
                if (is_send_step(step_next)) begin
                    bit_val = shift_next[7];
                end else if (step_next == ST_MACK) begin
                    bit_val = ({1'b0, bytec_next} + (COUNT_W+1)'(1)) >= {1'b0, count_next};
                end
                result.scl_out = (pidx_next == PH_MIDDLE);
                result.sda_out = bit_val;
            end

            pcnt_inc = {1'b0, pcnt_next} + (PHASE_W+1)'(1);
            pcnt_next = pcnt_inc[PHASE_W-1:0];
            if (pcnt_inc >= {1'b0, pt}) begin
                pcnt_next = '0;
                // sample at the end of scl high
                if ((pidx_next == PH_MIDDLE) && is_recv_step(step_next)) begin
                    if (step_next == ST_RECV) begin
                        shift_next = {shift_next[6:0], item.sda_in};
                        if (bitc_next == 4'd7) begin
                            result.read_valid = 1'b1;
                            result.read_byte  = shift_next;
                        end
                    end else if (item.sda_in) begin
                        nack_next = 1'b1;
                    end
                end

                if (pidx_next == PH_LAST) begin
                    pidx_next = PH_FIRST;
                    unique case (step_next)
                        ST_START1: begin
                            shift_next = {addr_next, RW_WRITE};
                            bitc_next  = '0;
                            step_next  = ST_ADDRW;
                        end
                        ST_ADDRW, ST_SUB, ST_DATA, ST_ADDRR: begin
                            shift_next = {shift_next[6:0], 1'b0};
                            if (bitc_next == 4'd7) begin
                                bitc_next = '0;
                                unique case (step_next)
                                    ST_ADDRW: step_next = ST_ACK1;
                                    ST_SUB:   step_next = ST_ACK2;
                                    ST_DATA:  step_next = ST_ACK3;
                                    default:  step_next = ST_ACK4;
                                endcase
                            end else begin
                                bitc_next = bitc_next + 4'd1;
                            end
                        end
                        ST_ACK1: begin
                            shift_next = sub_next;
                            bitc_next  = '0;
                            step_next  = ST_SUB;
                        end
                        ST_ACK2: begin
                            if (rd_next) begin
                                step_next = ST_STOPMID;
                            end else begin
                                shift_next = data_next;
                                bitc_next  = '0;
                                step_next  = ST_DATA;
                            end
                        end
                        ST_ACK3:    step_next = ST_STOPW;
                        ST_STOPMID: step_next = ST_START2;
                        ST_START2: begin
                            shift_next = {addr_next, RW_READ};
                            bitc_next  = '0;
                            step_next  = ST_ADDRR;
                        end
                        ST_ACK4: begin
                            bytec_next = '0;
                            bitc_next  = '0;
                            shift_next = '0;
                            step_next  = (count_next == '0) ? ST_MACK : ST_RECV;
                        end
                        ST_RECV: begin
                            if (bitc_next == 4'd7) begin
                                bitc_next = '0;
                                step_next = ST_MACK;
                            end else begin
                                bitc_next = bitc_next + 4'd1;
                            end
                        end
                        ST_MACK: begin
                            byte_inc   = {1'b0, bytec_next} + (COUNT_W+1)'(1);
                            bytec_next = byte_inc[COUNT_W-1:0];
                            if (bytec_next >= count_next) begin
                                step_next = ST_STOPR;
                            end else begin
                                bitc_next  = '0;
                                shift_next = '0;
                                step_next  = ST_RECV;
                            end
                        end
                        ST_STOPW, ST_STOPR: begin
                            step_next       = ST_IDLE;
                            result.done_res = 1'b1;
                        end
                        default: step_next = ST_IDLE;
                    endcase
                end else begin
                    pidx_next = pidx_next + 2'd1;
                end
            end
        end

        result.nack_seen = nack_next;
        result.busy_res  = (step_next != ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_IDLE;
            pcnt_reg  <= '0;
            pidx_reg  <= PH_FIRST;
            bitc_reg  <= '0;
            bytec_reg <= '0;
            shift_reg <= '0;
            addr_reg  <= '0;
            sub_reg   <= '0;
            data_reg  <= '0;
            count_reg <= '0;
            rd_reg    <= 1'b0;
            nack_reg  <= 1'b0;
        end else if (ctrl.step) begin
            step_reg  <= step_next;
            pcnt_reg  <= pcnt_next;
            pidx_reg  <= pidx_next;
            bitc_reg  <= bitc_next;
            bytec_reg <= bytec_next;
            shift_reg <= shift_next;
            addr_reg  <= addr_next;
            sub_reg   <= sub_next;
            data_reg  <= data_next;
            count_reg <= count_next;
            rd_reg    <= rd_next;
            nack_reg  <= nack_next;
        end
    end

endmodule

### rtl/core/i2c_register_transaction_master.sv
// top level: input register, config register, sequencer engine and result register
// depends on i2c_trm_pkg and i2c_trm_engine
`timescale 1ns / 1ps

//  channel  | ports                        | carries
//  ---------+------------------------------+----------------------------------------
//  input    | s_valid s_ready s_data       | one tick or command per transfer
//  result   | m_valid m_ready m_data       | pin levels and status, one per input
//  config   | cfg_we cfg_wdata             | phase_ticks, written without wait
//
// one transfer per cycle while m_ready keeps the result side moving; a result reaches m_data through
// the input register, then the single-pass sequencer update into the result register
// aresetn is synchronous, active low; it empties both registers and idles the bus
// a stalled result holds the result register; the input register keeps one more transfer
// and then s_ready drops until the result is taken

module i2c_register_transaction_master #(
    parameter int MAX_READ_BYTES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  i2c_trm_pkg::trm_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2c_trm_pkg::trm_out_t m_data,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata
);
    import i2c_trm_pkg::*;

    // input stage
    logic    in_valid_reg, in_valid_next;
    trm_in_t in_data_reg;

    // result stage
    logic     out_valid_reg, out_valid_next;
    trm_out_t out_data_reg;

    // configuration
    logic [PHASE_W-1:0] phase_ticks_reg;

    trm_ctrl_t ctrl;
    trm_out_t  eng_result;
    logic      advance;
    logic      s_take;

    // a held item moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    assign ctrl.step        = advance;
    assign ctrl.phase_ticks = phase_ticks_reg;

    i2c_trm_engine #(
        .MAX_READ_BYTES(MAX_READ_BYTES)
    ) u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .item   (in_data_reg),
        .result (eng_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_ticks_reg <= PHASE_W'(1);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                phase_ticks_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= eng_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### rtl/core/i2c_trm_checker.sv
// port-level checks for the i2c register transaction master, bound to the top level
// depends on i2c_trm_pkg and i2c_register_transaction_master
`timescale 1ns / 1ps

module i2c_trm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input i2c_trm_pkg::trm_out_t m_data
);
    import i2c_trm_pkg::*;

    // a stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // finishing a stop leaves the bus idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done with busy still set");

    // an idle bus is released on both lines
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.busy_res |-> m_data.scl_out && m_data.sda_out)
        else $error("lines driven while idle");

    // the byte field is zero unless a byte completed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.read_valid |-> m_data.read_byte == 8'd0)
        else $error("stray read byte");

    // a rejected command only happens during a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cmd_rejected |-> m_data.busy_res || m_data.done_res)
        else $error("command rejected while idle");

endmodule

bind i2c_register_transaction_master i2c_trm_checker u_i2c_trm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

### sim/tb_i2c_register_transaction_master.sv
// testbench for i2c_register_transaction_master: sends ticks and commands, predicts the pin
// levels and status of every tick with its own bus sequencer model, checks each result transfer
// depends on i2c_trm_pkg and the rtl top level i2c_register_transaction_master
`timescale 1ns / 1ps

module tb_i2c_register_transaction_master;
    import i2c_trm_pkg::*;

    localparam int         MAX_READ    = 16;
    localparam logic [1:0] MODE_SPARE  = 2'd3;   // unused mode code, behaves as a tick
    localparam int         MAX_REPORTS = 10;
    localparam int         IN_W        = $bits(trm_in_t);

    // how the slave answers on sda while a transaction runs
    typedef enum {SDA_ACK, SDA_NACK, SDA_MIXED} sda_drive_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    trm_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    trm_out_t    m_data;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int send_idle_pct = 27;
    int recv_idle_pct = 48;
    int items_sent    = 0;
    int error_count   = 0;

    // one expected result per accepted transfer, oldest first
    trm_out_t expected_pins[$];

    // bus sequencer model state
    logic [15:0] hold_ticks  = 16'd1;
    seq_state_t  bus_step    = ST_IDLE;
    logic [15:0] phase_cnt   = '0;
    logic [1:0]  phase_ph    = PH_FIRST;
    logic [3:0]  bit_cnt     = '0;
    logic [4:0]  byte_cnt    = '0;
    logic [7:0]  shifter     = '0;
    logic [6:0]  dev_addr    = '0;
    logic [7:0]  reg_addr    = '0;
    logic [7:0]  wr_byte     = '0;
    logic [4:0]  rd_len      = '0;
    logic        rd_txn      = 1'b0;
    logic        nack_sticky = 1'b0;
    logic        scl_lvl     = 1'b1;
    logic        sda_lvl     = 1'b1;

    i2c_register_transaction_master #(
        .MAX_READ_BYTES(MAX_READ)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // one tick of the bus sequencer: returns pin levels and status after this tick
    function automatic trm_out_t advance_bus(input trm_in_t item);
        trm_out_t    res;
        logic [15:0] span;
        res  = '0;
        // a zero phase length behaves as one tick
        span = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;

        // command latch, or reject when a transaction is running
        if (item.mode == MODE_WRITE || item.mode == MODE_READ) begin
            if (bus_step != ST_IDLE) begin
                res.cmd_rejected = 1'b1;
            end else begin
                dev_addr    = item.device_addr;
                reg_addr    = item.sub_addr;
                wr_byte     = item.write_data;
                rd_len      = (item.read_count > MAX_READ) ? 5'(MAX_READ) : item.read_count;
                rd_txn      = (item.mode == MODE_READ);
                nack_sticky = 1'b0;
                phase_cnt   = '0;
                phase_ph    = PH_FIRST;
                bit_cnt     = '0;
                byte_cnt    = '0;
                shifter     = '0;
                bus_step    = ST_START1;
            end
        end

        if (bus_step == ST_IDLE) begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
        end else begin
            // pin levels come from the step and phase before this tick advances them
            case (bus_step)
                ST_START1, ST_START2: begin
                    scl_lvl = (phase_ph != PH_LAST);
                    sda_lvl = (phase_ph == PH_FIRST);
                end
                ST_STOPW, ST_STOPMID, ST_STOPR: begin
                    scl_lvl = (phase_ph != PH_FIRST);
                    sda_lvl = (phase_ph == PH_LAST);
                end
                default: begin
                    scl_lvl = (phase_ph == PH_MIDDLE);
                    if (bus_step inside {ST_ADDRW, ST_SUB, ST_DATA, ST_ADDRR})
                        sda_lvl = shifter[7];
                    else if (bus_step == ST_MACK)
                        // nack after the last byte, ack before
                        sda_lvl = ({1'b0, byte_cnt} + 6'd1 >= {1'b0, rd_len});
                    else
                        sda_lvl = 1'b1;
                end
            endcase

            phase_cnt = phase_cnt + 16'd1;
            if (phase_cnt >= span) begin
                phase_cnt = '0;
                // sda is sampled at the end of the scl high phase
                if (phase_ph == PH_MIDDLE && bus_step == ST_RECV) begin
                    shifter = {shifter[6:0], item.sda_in};
                    if (bit_cnt == 4'd7) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = shifter;
                    end
                end else if (phase_ph == PH_MIDDLE && item.sda_in &&
                             bus_step inside {ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4}) begin
                    nack_sticky = 1'b1;
                end

                if (phase_ph != PH_LAST) begin
                    phase_ph = phase_ph + 2'd1;
                end else begin
                    // end of a bit or bus condition: move the sequence on
                    phase_ph = PH_FIRST;
                    case (bus_step)
                        ST_START1: begin
                            shifter  = {dev_addr, RW_WRITE};
                            bit_cnt  = '0;
                            bus_step = ST_ADDRW;
                        end
                        ST_ADDRW, ST_SUB, ST_DATA, ST_ADDRR: begin
                            bit_cnt = bit_cnt + 4'd1;
                            shifter = {shifter[6:0], 1'b0};
                            if (bit_cnt >= 4'd8) begin
                                bit_cnt = '0;
                                case (bus_step)
                                    ST_ADDRW: bus_step = ST_ACK1;
                                    ST_SUB:   bus_step = ST_ACK2;
                                    ST_DATA:  bus_step = ST_ACK3;
                                    default:  bus_step = ST_ACK4;
                                endcase
                            end
                        end
                        ST_ACK1: begin
                            shifter  = reg_addr;
                            bit_cnt  = '0;
                            bus_step = ST_SUB;
                        end
                        ST_ACK2: begin
                            if (rd_txn) begin
                                bus_step = ST_STOPMID;
                            end else begin
                                shifter  = wr_byte;
                                bit_cnt  = '0;
                                bus_step = ST_DATA;
                            end
                        end
                        ST_ACK3:    bus_step = ST_STOPW;
                        ST_STOPMID: bus_step = ST_START2;
                        ST_START2: begin
                            shifter  = {dev_addr, RW_READ};
                            bit_cnt  = '0;
                            bus_step = ST_ADDRR;
                        end
                        ST_ACK4: begin
                            byte_cnt = '0;
                            bit_cnt  = '0;
                            shifter  = '0;
                            // a zero-length read goes straight to the closing nack
                            if (rd_len == 5'd0) bus_step = ST_MACK;
                            else bus_step = ST_RECV;
                        end
                        ST_RECV: begin
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 4'd8) begin
                                bit_cnt  = '0;
                                bus_step = ST_MACK;
                            end
                        end
                        ST_MACK: begin
                            byte_cnt = byte_cnt + 5'd1;
                            if (byte_cnt >= rd_len) begin
                                bus_step = ST_STOPR;
                            end else begin
                                bit_cnt  = '0;
                                shifter  = '0;
                                bus_step = ST_RECV;
                            end
                        end
                        ST_STOPW, ST_STOPR: begin
                            bus_step     = ST_IDLE;
                            res.done_res = 1'b1;
                        end
                        default: bus_step = ST_IDLE;
                    endcase
                end
            end
        end

        res.scl_out   = scl_lvl;
        res.sda_out   = sda_lvl;
        res.nack_seen = nack_sticky;
        res.busy_res  = (bus_step != ST_IDLE);
        return res;
    endfunction

    function automatic trm_in_t make_tick(input logic sda);
        trm_in_t t;
        // unused fields carry random bits, the block must ignore them
        t        = trm_in_t'(IN_W'($urandom));
        t.mode   = MODE_TICK;
        t.sda_in = sda;
        return t;
    endfunction

    function automatic trm_in_t make_cmd(input logic [1:0] mode, input logic [6:0] addr,
                                         input logic [7:0] sub, input logic [7:0] data,
                                         input logic [4:0] count, input logic sda);
        trm_in_t t;
        t.mode        = mode;
        t.device_addr = addr;
        t.sub_addr    = sub;
        t.write_data  = data;
        t.read_count  = count;
        t.sda_in      = sda;
        return t;
    endfunction

    function automatic logic pick_sda(input sda_drive_t how);
        case (how)
            SDA_ACK:  return 1'b0;
            SDA_NACK: return 1'b1;
            default:  return 1'($urandom_range(1));
        endcase
    endfunction

    // one input transfer, with random idle cycles before it; valid stays high on return
    task automatic send_item(input trm_in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_pins.push_back(advance_bus(item));
        items_sent++;
    endtask

    // phase length write, only once every pending result has come back
    task automatic write_cfg(input logic [15:0] value);
        s_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        hold_ticks  = value;
    endtask

    task automatic set_idling(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
    endtask

    // keep ticking until the running transaction has sent its final stop
    task automatic finish_bus(input sda_drive_t how);
        while (bus_step != ST_IDLE) send_item(make_tick(pick_sda(how)));
    endtask

    task automatic note_error(input string what, input trm_out_t want, input trm_out_t got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, what);
            $display("  want scl=%0b sda=%0b byte=%02h vld=%0b nack=%0b busy=%0b done=%0b rej=%0b",
                     want.scl_out, want.sda_out, want.read_byte, want.read_valid,
                     want.nack_seen, want.busy_res, want.done_res, want.cmd_rejected);
            $display("  got  scl=%0b sda=%0b byte=%02h vld=%0b nack=%0b busy=%0b done=%0b rej=%0b",
                     got.scl_out, got.sda_out, got.read_byte, got.read_valid,
                     got.nack_seen, got.busy_res, got.done_res, got.cmd_rejected);
        end
    endtask

    // result side: compare each transfer with the oldest expectation, stall at random
    always @(posedge aclk) begin
        trm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pins.size() == 0) begin
                note_error("result transfer with nothing expected", '0, m_data);
            end else begin
                want = expected_pins.pop_front();
                if (m_data.scl_out      !== want.scl_out      ||
                    m_data.sda_out      !== want.sda_out      ||
                    m_data.read_byte    !== want.read_byte    ||
                    m_data.read_valid   !== want.read_valid   ||
                    m_data.nack_seen    !== want.nack_seen    ||
                    m_data.busy_res     !== want.busy_res     ||
                    m_data.done_res     !== want.done_res     ||
                    m_data.cmd_rejected !== want.cmd_rejected)
                    note_error("result mismatch", want, m_data);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // idle bus: plain ticks and the spare mode, sda both ways
    task automatic test_idle_ticks();
        trm_in_t t;
        send_item(make_tick(1'b0));
        send_item(make_tick(1'b1));
        t      = make_tick(1'b0);
        t.mode = MODE_SPARE;
        send_item(t);
        t.sda_in = 1'b1;
        send_item(t);
    endtask

    // write with all-ones address and sub-address, every acknowledge nacked;
    // commands that arrive while it runs are dropped and flagged
    task automatic test_busy_reject();
        send_item(make_cmd(MODE_WRITE, 7'h7F, 8'hFF, 8'h00, 5'd0, 1'b1));
        repeat (10) send_item(make_tick(1'b1));
        send_item(make_cmd(MODE_READ, 7'h6A, 8'h11, 8'h00, 5'd3, 1'b1));
        send_item(make_cmd(MODE_SPARE, 7'h01, 8'h02, 8'h03, 5'd4, 1'b1));
        send_item(make_cmd(MODE_WRITE, 7'h33, 8'h77, 8'h99, 5'd1, 1'b1));
        finish_bus(SDA_NACK);
    endtask

    // reads of zero and two bytes
    task automatic test_read_counts();
        send_item(make_cmd(MODE_READ, 7'($urandom), 8'($urandom), 8'($urandom), 5'd0, 1'b0));
        finish_bus(SDA_ACK);
        send_item(make_cmd(MODE_READ, 7'($urandom), 8'($urandom), 8'($urandom), 5'd2, 1'b0));
        finish_bus(SDA_MIXED);
    endtask

    // a zero phase length must run at one tick per phase; all-zero address fields
    task automatic test_zero_phase();
        write_cfg(16'd0);
        send_item(make_cmd(MODE_WRITE, 7'h00, 8'h00, 8'hFF, 5'd31, 1'b1));
        finish_bus(SDA_ACK);
    endtask

    // one command with random content, followed by ticks until its stop has gone out
    task automatic random_transaction();
        trm_in_t item;
        int      bias;
        int      roll;
        // per transaction share of high sda samples: 0, 25, 50 or 75 percent
        bias = $urandom_range(3);
        // some noise ahead of the command
        if ($urandom_range(9) == 0) begin
            item = trm_in_t'(IN_W'($urandom));
            if (item.mode == MODE_WRITE || item.mode == MODE_READ) item.mode = MODE_SPARE;
            send_item(item);
        end
        item      = trm_in_t'(IN_W'($urandom));
        item.mode = $urandom_range(1) ? MODE_READ : MODE_WRITE;
        // short reads only
        item.read_count = 5'($urandom_range(3));
        item.sda_in = ($urandom_range(3) < bias);
        send_item(item);
        while (bus_step != ST_IDLE) begin
            item = trm_in_t'(IN_W'($urandom));
            roll = $urandom_range(19);
            if (roll == 0)
                item.mode = $urandom_range(1) ? MODE_READ : MODE_WRITE;
            else if (roll == 1)
                item.mode = MODE_SPARE;
            else
                item.mode = MODE_TICK;
            item.sda_in = ($urandom_range(3) < bias);
            send_item(item);
        end
        repeat ($urandom_range(3)) send_item(make_tick(1'($urandom_range(1))));
    endtask

    task automatic test_random_traffic(input logic [15:0] span, input int count);
        int start;
        write_cfg(span);
        start = items_sent;
        while (items_sent - start < count) random_transaction();
    endtask

    // longest phase holds the start condition, then a drop to one tick mid-phase
    task automatic test_long_phase();
        write_cfg(16'hFFFF);
        send_item(make_cmd(MODE_WRITE, 7'h2A, 8'h3C, 8'h5A, 5'd0, 1'b0));
        repeat (6) send_item(make_tick(1'b0));
        write_cfg(16'd1);
        finish_bus(SDA_MIXED);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles less than the receiver
        test_idle_ticks();
        test_busy_reject();

        // receiver idles less than the sender
        set_idling(48, 27);
        test_read_counts();
        test_zero_phase();

        // no idling on either side
        set_idling(0, 0);
        test_long_phase();
        test_random_traffic(16'd1, 60);

        s_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge aclk);
        // catch any stray result after the last one
        repeat (10) @(posedge aclk);
        error_count += expected_pins.size();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit, several times the slowest correct run
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### i2c_register_transaction_master.f
rtl/core/i2c_trm_pkg.sv
rtl/core/i2c_trm_engine.sv
rtl/core/i2c_register_transaction_master.sv
rtl/core/i2c_trm_checker.sv
sim/tb_i2c_register_transaction_master.sv
